// ===== design/pts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Priority thread scheduler package
// Widths, action and error codes, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int THREAD_COUNT_DEFAULT = 16;
   localparam int ACTION_W             = 2;
   localparam int PRIO_W               = 4;
   localparam int TICKS_W              = 32;
   localparam int ERR_W                = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 2'd0,
      ACT_DELAY    = 2'd1,
      ACT_START    = 2'd2,
      ACT_SCHEDULE = 2'd3
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK   = 2'd0,
      ERR_PRIO = 2'd1,
      ERR_IDLE = 2'd2,
      ERR_ZERO = 2'd3
   } err_type;

   typedef struct packed {
      logic    walk_init;
      logic    walk_step;
      logic    start_apply;
      logic    delay_apply;
      logic    schedule;
      logic    respond_hold;
      err_type hold_err;
   } dp_cmd_type;

   typedef struct packed {
      err_type start_err;
      err_type delay_err;
      logic    walk_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== design/pts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences each request: immediate reply, timeout walk, or schedule.
// ----------------------------------------------------------------------------
module pts_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pts_pkg::ACTION_W-1:0]  req_action,
   input  wire pts_pkg::dp_status_type        status,
   output pts_pkg::dp_cmd_type                cmd,
   output logic                               busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SCHED
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   pts_pkg::action_type action;

   assign action = pts_pkg::action_type'(req_action);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (action)
                  pts_pkg::ACT_TICK: begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_WALK;
                  end
                  pts_pkg::ACT_DELAY: begin
                     if (status.delay_err == pts_pkg::ERR_OK) begin
                        cmd.delay_apply = 1'b1;
                        state_in        = ST_SCHED;
                     end else begin
                        cmd.respond_hold = 1'b1;
                        cmd.hold_err     = status.delay_err;
                     end
                  end
                  pts_pkg::ACT_START: begin
                     cmd.start_apply  = (status.start_err == pts_pkg::ERR_OK);
                     cmd.respond_hold = 1'b1;
                     cmd.hold_err     = status.start_err;
                  end
                  pts_pkg::ACT_SCHEDULE: begin
                     state_in = ST_SCHED;
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCHED;
         end
         ST_SCHED: begin
            cmd.schedule = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/pts_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler datapath
// Thread masks, timeout memory with pipelined walk, priority pick, result regs.
// ----------------------------------------------------------------------------
module pts_datapath #(
   parameter int THREAD_COUNT = pts_pkg::THREAD_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pts_pkg::dp_cmd_type           cmd,
   output pts_pkg::dp_status_type             status,
   input  wire logic [pts_pkg::PRIO_W-1:0]    req_priority_req,
   input  wire logic [pts_pkg::TICKS_W-1:0]   req_delay_ticks,
   output logic                               rsp_valid,
   output logic [pts_pkg::PRIO_W-1:0]         rsp_next_thread,
   output logic                               rsp_switch_needed,
   output logic [pts_pkg::ERR_W-1:0]          rsp_error_code
);

   localparam int                IDX_W    = $clog2(THREAD_COUNT);
   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(THREAD_COUNT - 1);
   localparam logic [IDX_W-1:0]  FIRST_IDX = IDX_W'(1);

   logic [THREAD_COUNT-1:0]         ready_ff, ready_in;
   logic [THREAD_COUNT-1:0]         delayed_ff, delayed_in;
   logic [THREAD_COUNT-1:0]         registered_ff, registered_in;
   logic [IDX_W-1:0]                current_ff, current_in;

   logic [pts_pkg::TICKS_W-1:0]     timeout_mem [THREAD_COUNT];
   logic [pts_pkg::TICKS_W-1:0]     rdata_ff;
   logic [IDX_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]                stage_idx_ff;
   logic                            stage_valid_ff;
   logic                            stage_hit;
   logic [pts_pkg::TICKS_W-1:0]     decremented;

   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   logic [pts_pkg::TICKS_W-1:0]     mem_wdata;

   logic [IDX_W-1:0]                prio_idx;
   logic                            prio_in_range;
   logic [IDX_W-1:0]                pick;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pts_pkg::PRIO_W-1:0]      rsp_next_ff, rsp_next_in;
   logic                            rsp_switch_ff, rsp_switch_in;
   pts_pkg::err_type                rsp_err_ff, rsp_err_in;

   assign prio_idx      = IDX_W'(req_priority_req);
   assign prio_in_range = (32'(req_priority_req) < 32'(THREAD_COUNT));

   always_comb begin
      status.start_err = (!prio_in_range || registered_ff[prio_idx]) ?
                         pts_pkg::ERR_PRIO : pts_pkg::ERR_OK;
      if (current_ff == '0) begin
         status.delay_err = pts_pkg::ERR_IDLE;
      end else if (req_delay_ticks == '0) begin
         status.delay_err = pts_pkg::ERR_ZERO;
      end else begin
         status.delay_err = pts_pkg::ERR_OK;
      end
      status.walk_last = (rd_idx_ff == LAST_IDX);
   end

   // highest ready priority, idle when none
   always_comb begin
      pick = '0;
      for (int p = 1; p < THREAD_COUNT; p++) begin
         if (ready_ff[p]) begin
            pick = IDX_W'(p);
         end
      end
   end

   // timeout walk: saturating decrement, release on zero
   assign decremented = (rdata_ff != '0) ? (rdata_ff - pts_pkg::TICKS_W'(1)) : '0;
   assign stage_hit   = stage_valid_ff && delayed_ff[stage_idx_ff];

   always_comb begin
      ready_in      = ready_ff;
      delayed_in    = delayed_ff;
      registered_in = registered_ff;
      current_in    = current_ff;
      rd_idx_in     = rd_idx_ff;

      if (cmd.start_apply) begin
         registered_in[prio_idx] = 1'b1;
         ready_in[prio_idx]      = 1'b1;
      end
      if (cmd.delay_apply) begin
         ready_in[current_ff]   = 1'b0;
         delayed_in[current_ff] = 1'b1;
      end
      if (stage_hit && (decremented == '0)) begin
         ready_in[stage_idx_ff]   = 1'b1;
         delayed_in[stage_idx_ff] = 1'b0;
      end

      priority if (cmd.walk_init) begin
         rd_idx_in = FIRST_IDX;
      end else if (cmd.walk_step) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end

      if (cmd.schedule) begin
         current_in = pick;
      end
   end

   always_comb begin
      mem_we    = cmd.delay_apply || stage_hit;
      mem_waddr = cmd.delay_apply ? current_ff : stage_idx_ff;
      mem_wdata = cmd.delay_apply ? req_delay_ticks : decremented;
   end

   always_comb begin
      rsp_valid_in  = cmd.schedule || cmd.respond_hold;
      rsp_next_in   = pts_pkg::PRIO_W'(cmd.schedule ? pick : current_ff);
      rsp_switch_in = cmd.schedule && (pick != current_ff);
      rsp_err_in    = cmd.schedule ? pts_pkg::ERR_OK : cmd.hold_err;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         timeout_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.walk_step) begin
         rdata_ff <= timeout_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff       <= '0;
         delayed_ff     <= '0;
         registered_ff  <= THREAD_COUNT'(1);
         current_ff     <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ready_ff       <= ready_in;
         delayed_ff     <= delayed_in;
         registered_ff  <= registered_in;
         current_ff     <= current_in;
         stage_valid_ff <= cmd.walk_step;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      stage_idx_ff  <= rd_idx_ff;
      rsp_next_ff   <= rsp_next_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_thread   = rsp_next_ff;
   assign rsp_switch_needed = rsp_switch_ff;
   assign rsp_error_code    = rsp_err_ff;

`ifndef SYNTH
   a_ready_delayed_disjoint: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & delayed_ff) == '0)
      else $error("thread both ready and delayed");

   a_idle_never_queued: assert property (@(posedge clock) disable iff (reset)
      !ready_ff[0] && !delayed_ff[0])
      else $error("idle thread in ready or delayed mask");

   a_idle_registered: assert property (@(posedge clock) disable iff (reset)
      registered_ff[0])
      else $error("idle thread lost registration");

   a_queued_registered: assert property (@(posedge clock) disable iff (reset)
      ((ready_ff | delayed_ff) & ~registered_ff) == '0)
      else $error("unregistered thread ready or delayed");

   a_no_switch_on_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.respond_hold |=> rsp_valid_ff && !rsp_switch_ff)
      else $error("switch flagged on a non-scheduling transfer");
`endif

endmodule
`default_nettype wire

// ===== design/priority_thread_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Priority thread scheduler
// Bitmask RTOS scheduler with per-priority delay timeouts.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low; each request gives
// exactly one result, shown for a single cycle with rsp_valid and never held,
// so the receiver must take it then. Start requests and rejected delays reply
// in the next cycle and leave busy low. Delay and schedule requests pass
// through the schedule state with busy high for one cycle and then reply
// from the result registers. A tick walks the timeout memory one entry per
// cycle through its single read port; busy stays high through the walk, drain
// and schedule states. The timeout memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module priority_thread_scheduler #(
   parameter int THREAD_COUNT = pts_pkg::THREAD_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pts_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [pts_pkg::PRIO_W-1:0]    req_priority_req,
   input  wire logic [pts_pkg::TICKS_W-1:0]   req_delay_ticks,
   output logic                               rsp_valid,
   output logic [pts_pkg::PRIO_W-1:0]         rsp_next_thread,
   output logic                               rsp_switch_needed,
   output logic [pts_pkg::ERR_W-1:0]          rsp_error_code
);

   pts_pkg::dp_cmd_type    cmd;
   pts_pkg::dp_status_type status;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   pts_datapath #(
      .THREAD_COUNT (THREAD_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_priority_req  (req_priority_req),
      .req_delay_ticks   (req_delay_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_next_thread   (rsp_next_thread),
      .rsp_switch_needed (rsp_switch_needed),
      .rsp_error_code    (rsp_error_code)
   );

endmodule
`default_nettype wire
